FILE: hw/rtl/flt_pkg.sv
// shared types and constants for the fraction reduction block
// no dependencies; imported by the interfaces and every module

package flt_pkg;

   localparam int unsigned DATA_BITS  = 31;
   localparam int unsigned SHIFT_BITS = $clog2(DATA_BITS + 1);

   typedef logic [DATA_BITS-1:0]  part_type;
   typedef logic [SHIFT_BITS-1:0] shift_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_OUT
   } state_type;

endpackage

FILE: hw/rtl/flt_req_if.sv
// request channel: numerator and denominator with valid/ready
// depends on flt_pkg

interface flt_req_if;
   import flt_pkg::*;

   logic     valid;
   logic     ready;
   part_type numerator;
   part_type denominator;

   modport source (output valid, numerator, denominator, input ready);
   modport sink (input valid, numerator, denominator, output ready);
endinterface

FILE: hw/rtl/flt_rsp_if.sv
// response channel: reduced numerator and denominator with valid/ready
// depends on flt_pkg

interface flt_rsp_if;
   import flt_pkg::*;

   logic     valid;
   logic     ready;
   part_type reduced_numerator;
   part_type reduced_denominator;

   modport source (output valid, reduced_numerator, reduced_denominator, input ready);
   modport sink (input valid, reduced_numerator, reduced_denominator, output ready);
endinterface

FILE: hw/rtl/flt_gcd.sv
// binary gcd unit: one subtract/compare/shift step per cycle
// depends on flt_pkg

module flt_gcd (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  flt_pkg::part_type        opa,
   input  flt_pkg::part_type        opb,
   output flt_pkg::unit_status_type status,
   output flt_pkg::part_type        gcd
);
   import flt_pkg::*;

   part_type           a_ff, a_in;
   part_type           b_ff, b_in;
   shift_type          k_ff, k_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DATA_BITS:0] diff;
   part_type           mag;

   // shared subtractor, magnitude of the difference
   assign diff = {1'b0, a_ff} - {1'b0, b_ff};
   assign mag  = diff[DATA_BITS] ? part_type'(~diff[DATA_BITS-1:0] + 1'b1)
                                 : diff[DATA_BITS-1:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = opa;
         b_in    = opb;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == b_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            case ({a_ff[0], b_ff[0]})
               2'b00: begin
                  // common factor of two
                  a_in = a_ff >> 1;
                  b_in = b_ff >> 1;
                  k_in = shift_type'(k_ff + 1'b1);
               end
               2'b01:   a_in = a_ff >> 1;
               2'b10:   b_in = b_ff >> 1;
               default: begin
                  // both odd: larger becomes half the difference
                  if (diff[DATA_BITS]) begin
                     b_in = mag >> 1;
                  end else begin
                     a_in = mag >> 1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign gcd         = a_ff << k_ff;

endmodule

FILE: hw/rtl/flt_div.sv
// restoring divider: one quotient bit per cycle, DATA_BITS quotient bits per division
// depends on flt_pkg

module flt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  flt_pkg::part_type        dividend,
   input  flt_pkg::part_type        divisor,
   output flt_pkg::unit_status_type status,
   output flt_pkg::part_type        quotient
);
   import flt_pkg::*;

   part_type             rem_ff, rem_in;
   part_type             q_ff, q_in;
   part_type             dvs_ff, dvs_in;
   shift_type            cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_BITS:0]   rem_sh;
   logic [DATA_BITS+1:0] trial;

   assign rem_sh = {rem_ff, q_ff[DATA_BITS-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         q_in    = dividend;
         dvs_in  = divisor;
         cnt_in  = shift_type'(DATA_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DATA_BITS+1]) begin
            rem_in = rem_sh[DATA_BITS-1:0];
            q_in   = {q_ff[DATA_BITS-2:0], 1'b0};
         end else begin
            rem_in = trial[DATA_BITS-1:0];
            q_in   = {q_ff[DATA_BITS-2:0], 1'b1};
         end
         cnt_in = shift_type'(cnt_ff - 1'b1);
         if (cnt_ff == shift_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

FILE: hw/rtl/fraction_lowest_terms.sv
// fraction to lowest terms: binary gcd, then the shared divider twice.
// a fraction with a zero part goes straight to the output state; otherwise it passes
//   through the gcd, numerator division and denominator division states first.
// one beat at a time: a new beat is taken only once the previous one has left
//   the sequencer; the response register lets it wait downstream meanwhile.
// synchronous reset clears the sequencer and the response valid flag.

module fraction_lowest_terms (
   input logic      clock,
   input logic      reset,
   flt_req_if.sink   req_bus,
   flt_rsp_if.source rsp_bus
);
   import flt_pkg::*;

   state_type       state_ff, state_in;
   part_type        num_ff, num_in;
   part_type        den_ff, den_in;
   part_type        res_num_ff, res_num_in;
   part_type        res_den_ff, res_den_in;
   part_type        out_num_ff, out_num_in;
   part_type        out_den_ff, out_den_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            accept;
   logic            zero_part;
   logic            out_free;
   logic            gcd_start;
   logic            div_start;
   logic            load_out;
   unit_status_type gcd_status;
   unit_status_type div_status;
   part_type        gcd;
   part_type        quotient;
   part_type        div_dividend;

   assign zero_part = (req_bus.numerator == '0) || (req_bus.denominator == '0);
   assign accept    = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // the gcd unit loads straight from the accepted beat
   flt_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .opa    (req_bus.numerator),
      .opb    (req_bus.denominator),
      .status (gcd_status),
      .gcd    (gcd)
   );

   assign div_dividend = (state_ff == ST_GCD) ? num_ff : den_ff;

   flt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd),
      .status   (div_status),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = zero_part ? ST_OUT : ST_GCD;
            end
         end
         ST_GCD:     if (gcd_status.done) state_in = ST_DIV_NUM;
         ST_DIV_NUM: if (div_status.done) state_in = ST_DIV_DEN;
         ST_DIV_DEN: if (div_status.done) state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      gcd_start     = 1'b0;
      div_start     = 1'b0;
      load_out      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            gcd_start     = req_bus.valid && !zero_part;
         end
         ST_GCD:     div_start = gcd_status.done;
         ST_DIV_NUM: div_start = div_status.done;
         ST_DIV_DEN: ;
         ST_OUT:     load_out = out_free;
         default:    ;
      endcase
   end

   // datapath registers
   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      if (accept) begin
         num_in     = req_bus.numerator;
         den_in     = req_bus.denominator;
         res_num_in = req_bus.numerator;
         res_den_in = req_bus.denominator;
      end
      if (state_ff == ST_DIV_NUM && div_status.done) begin
         res_num_in = quotient;
      end
      if (state_ff == ST_DIV_DEN && div_status.done) begin
         res_den_in = quotient;
      end
      if (load_out) begin
         out_num_in = res_num_ff;
         out_den_in = res_den_ff;
      end
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.reduced_numerator   = out_num_ff;
   assign rsp_bus.reduced_denominator = out_den_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for fraction_lowest_terms: directed rows, then random fractions
// depends on flt_pkg, flt_req_if, flt_rsp_if and the fraction_lowest_terms rtl

module tb_top;
   import flt_pkg::*;

   typedef struct packed {
      part_type num;
      part_type den;
   } fraction_type;

   typedef struct packed {
      part_type     num;
      part_type     den;
      logic         typed;
      fraction_type result;
   } fraction_row_type;

   localparam part_type    PART_MAX     = '1;
   localparam int unsigned RANDOM_ITEMS = 1628;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned DIRECTED_N   = 22;

   localparam fraction_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      '{31'd0,           31'd0,           1'b1, '{31'd0,       31'd0}},
      '{31'd0,           31'd5,           1'b1, '{31'd0,       31'd5}},
      '{31'd7,           31'd0,           1'b1, '{31'd7,       31'd0}},
      '{31'd0,           PART_MAX,        1'b1, '{31'd0,       PART_MAX}},
      '{PART_MAX,        31'd0,           1'b1, '{PART_MAX,    31'd0}},
      '{31'd1,           31'd1,           1'b1, '{31'd1,       31'd1}},
      '{PART_MAX,        PART_MAX,        1'b1, '{31'd1,       31'd1}},
      '{PART_MAX,        31'd1,           1'b1, '{PART_MAX,    31'd1}},
      '{31'd1,           PART_MAX,        1'b1, '{31'd1,       PART_MAX}},
      '{31'd6,           31'd4,           1'b1, '{31'd3,       31'd2}},
      '{31'd12,          31'd18,          1'b1, '{31'd2,       31'd3}},
      '{31'h40000000,    31'h20000000,    1'b1, '{31'd2,       31'd1}},
      '{31'd7,           31'd13,          1'b1, '{31'd7,       31'd13}},
      '{PART_MAX,        PART_MAX - 1'b1, 1'b1, '{PART_MAX,    PART_MAX - 1'b1}},
      '{31'd1071,        31'd462,         1'b0, '{31'd0,       31'd0}},
      '{31'h55555555,    31'h2AAAAAAA,    1'b0, '{31'd0,       31'd0}},
      '{31'h40000000,    31'd1162261467,  1'b0, '{31'd0,       31'd0}},
      '{31'd1134903170,  31'd1836311903,  1'b0, '{31'd0,       31'd0}},
      '{31'd2147483646,  31'd1073741823,  1'b0, '{31'd0,       31'd0}},
      '{31'h7FFFFFF0,    31'h00000010,    1'b0, '{31'd0,       31'd0}},
      '{31'd92682,       31'd139023,      1'b0, '{31'd0,       31'd0}},
      '{31'h2AAAAAAA,    31'h7FFFFFFE,    1'b0, '{31'd0,       31'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   flt_req_if req_if ();
   flt_rsp_if rsp_if ();

   fraction_lowest_terms uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   fraction_type lowest_terms_q [$];
   int unsigned  error_count   = 0;
   bit           idle_on       = 1'b0;
   bit           hold_sink_req = 1'b0;

   always #5 clock = ~clock;

   // euclid on the part width; a zero part passes the fraction straight through
   function automatic fraction_type lowest_terms_of(part_type n, part_type d);
      fraction_type res;
      part_type     a;
      part_type     b;
      part_type     r;
      res.num = n;
      res.den = d;
      if (n != '0 && d != '0) begin
         a = n;
         b = d;
         while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
         end
         res.num = n / a;
         res.den = d / a;
      end
      return res;
   endfunction

   function automatic part_type rand_bits(int unsigned w);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (w == 0)
         return '0;
      return part_type'(v & ((64'd1 << w) - 64'd1));
   endfunction

   // random fraction, weighted towards shared factors so the gcd is rarely trivial
   function automatic fraction_type make_fraction();
      fraction_type f;
      int unsigned  pick;
      int unsigned  w;
      part_type     g;
      pick = $urandom_range(0, 99);
      w    = $urandom_range(1, 30);
      g    = rand_bits(w);
      if (pick < 35) begin
         f.num = part_type'(g * rand_bits(31 - w));
         f.den = part_type'(g * rand_bits(31 - w));
      end else if (pick < 60) begin
         f.num = part_type'($urandom);
         f.den = part_type'($urandom);
      end else if (pick < 70) begin
         f.num = $urandom_range(0, 1) ? '0 : part_type'($urandom);
         f.den = (f.num != '0 && $urandom_range(0, 2) != 0) ? '0 : part_type'($urandom);
      end else if (pick < 80) begin
         f.num = part_type'($urandom_range(0, 64));
         f.den = part_type'($urandom_range(0, 64));
      end else if (pick < 90) begin
         f.num = part_type'($urandom) << $urandom_range(0, 30);
         f.den = part_type'($urandom) << $urandom_range(0, 30);
      end else begin
         // one part a multiple of the other
         f.den = g;
         f.num = part_type'(g * rand_bits(31 - w));
         if ($urandom_range(0, 1) != 0)
            f = '{num: f.den, den: f.num};
      end
      return f;
   endfunction

   task automatic send_fraction(part_type n, part_type d, bit typed, fraction_type typed_result);
      int unsigned gap;
      req_if.valid       <= 1'b1;
      req_if.numerator   <= n;
      req_if.denominator <= d;
      do @(posedge clock); while (!req_if.ready);
      lowest_terms_q.push_back(typed ? typed_result : lowest_terms_of(n, d));
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender
   initial begin
      fraction_type f;
      req_if.valid       <= 1'b0;
      req_if.numerator   <= '0;
      req_if.denominator <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      for (int unsigned i = 0; i < DIRECTED_N; i++)
         send_fraction(DIRECTED_ROWS[i].num, DIRECTED_ROWS[i].den,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 128 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         if (i >= RANDOM_ITEMS - 150)
            idle_on = 1'b0;
         if (i == 300)
            hold_sink_req = 1'b1;
         if (i == 900) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (lowest_terms_q.size() != 0);
         end
         f = make_fraction();
         send_fraction(f.num, f.den, 1'b0, f);
      end
      req_if.valid <= 1'b0;

      while (lowest_terms_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("fraction_lowest_terms: match");
      else
         $display("fraction_lowest_terms: mismatch");
      $finish;
   end

   // receiver: random stalls, plus one long hold so the block backs up
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (hold_sink_req) begin
            hold_sink_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // compare every result beat with the oldest expectation
   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (lowest_terms_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, actual %0d/%0d", $time,
                     rsp_if.reduced_numerator, rsp_if.reduced_denominator);
         end else begin
            want = lowest_terms_q.pop_front();
            if (rsp_if.reduced_numerator !== want.num) begin
               error_count++;
               $display("%0t: reduced_numerator expected %0d, actual %0d", $time,
                        want.num, rsp_if.reduced_numerator);
            end
            if (rsp_if.reduced_denominator !== want.den) begin
               error_count++;
               $display("%0t: reduced_denominator expected %0d, actual %0d", $time,
                        want.den, rsp_if.reduced_denominator);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("fraction_lowest_terms: mismatch");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/flt_pkg.sv
hw/rtl/flt_req_if.sv
hw/rtl/flt_rsp_if.sv
hw/rtl/flt_gcd.sv
hw/rtl/flt_div.sv
hw/rtl/fraction_lowest_terms.sv
verif/tb_top.sv
